>>> sv/fssc_pkg.sv
// Package for the frame, subframe and slot counter.
// Holds widths, constants, stage structures and the small divide-by-ten helper.
// Has no dependencies; the counter modules and the testbench import it.
package fssc_pkg;

	localparam int FRAME_BITS    = 32;
	localparam int ABS_W         = 41;
	localparam int QUOT_W        = 29;
	localparam int SUM_W         = 33;
	localparam logic [2:0] MAX_NUMEROLOGY = 3'd5;
	localparam logic [3:0] SUBFRAMES      = 4'd10;
	localparam logic [31:0] RECIP10       = 32'hCCCCCCCD;

	localparam logic OP_ADVANCE = 1'b0;
	localparam logic OP_LOAD    = 1'b1;

	typedef struct packed {
		logic        opcode;
		logic [31:0] slot_count;
		logic [63:0] load_encoding;
		logic [63:0] probe_encoding;
		logic [7:0]  sym_start;
	} item_t;

	typedef struct packed {
		logic                  opcode;
		logic [4:0]            cnt_lo;
		logic [3:0]            cnt_hi_lsb;
		logic [QUOT_W-1:0]     cnt_quot;
		logic [FRAME_BITS-1:0] ld_frame;
		logic [3:0]            ld_sub;
		logic [4:0]            ld_slot;
		logic                  refused;
		logic                  mismatch;
		logic [FRAME_BITS-1:0] pr_frame;
		logic [7:0]            pr_sub;
		logic [7:0]            pr_slot;
		logic [7:0]            sym_start;
	} dec_t;

	typedef struct packed {
		logic [FRAME_BITS-1:0] frame;
		logic [3:0]            sub;
		logic [4:0]            slot;
	} ctr_t;

	typedef struct packed {
		ctr_t                  ctr;
		logic                  refused;
		logic                  mismatch;
		logic [FRAME_BITS-1:0] pr_frame;
		logic [7:0]            pr_sub;
		logic [7:0]            pr_slot;
		logic [7:0]            sym_start;
	} post_t;

	typedef struct packed {
		logic [31:0]      frame_number;
		logic [3:0]       subframe_number;
		logic [4:0]       slot_number;
		logic [ABS_W-1:0] absolute_slot;
		logic [63:0]      time_encoding;
		logic             is_before_probe;
		logic             equals_probe;
		logic             numerology_mismatch;
		logic             load_refused;
	} res_t;

	typedef struct packed {
		logic [3:0] q;
		logic [3:0] r;
	} qr_t;

	// Quotient and remainder by ten for values up to 127, by reciprocal.
	function automatic qr_t div10_small(input logic [6:0] s);
		logic [14:0] p;
		qr_t         res;
		p     = 15'(s) * 15'd205;
		res.q = p[14:11];
		res.r = 4'(7'(s) - 7'(res.q) * 7'(SUBFRAMES));
		return res;
	endfunction

endpackage

>>> sv/fssc_in_if.sv
// Input channel of the counter: valid, ready and one item.
// Depends on fssc_pkg for nothing but shares its field widths.
interface fssc_in_if;
	logic        valid;
	logic        ready;
	logic        opcode;
	logic [31:0] slot_count;
	logic [63:0] load_encoding;
	logic [63:0] probe_encoding;
	logic [7:0]  sym_start;

	modport source (output valid, opcode, slot_count, load_encoding, probe_encoding,
		sym_start, input ready);
	modport sink (input valid, opcode, slot_count, load_encoding, probe_encoding,
		sym_start, output ready);
endinterface

>>> sv/fssc_out_if.sv
// Result channel of the counter: valid, ready and one result.
// Field widths follow fssc_pkg.
interface fssc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] frame_number;
	logic [3:0]  subframe_number;
	logic [4:0]  slot_number;
	logic [40:0] absolute_slot;
	logic [63:0] time_encoding;
	logic        is_before_probe;
	logic        equals_probe;
	logic        numerology_mismatch;
	logic        load_refused;

	modport source (output valid, frame_number, subframe_number, slot_number,
		absolute_slot, time_encoding, is_before_probe, equals_probe,
		numerology_mismatch, load_refused, input ready);
	modport sink (input valid, frame_number, subframe_number, slot_number,
		absolute_slot, time_encoding, is_before_probe, equals_probe,
		numerology_mismatch, load_refused, output ready);
endinterface

>>> sv/frame_subframe_slot_counter.sv
// Frame, subframe and slot counter with mixed-radix advance and encoded load.
// Four register stages: item_s1, dec_s2, post_s3 and res_s4; results leave from res_s4.
// One item per cycle unless results stall; the counter registers step in the second stage.
// Result stalls hold full stages with no bubble ahead; items enter while any stage has room.
// Asynchronous active-low reset clears the counter to zero and numerology to zero.
// Depends on fssc_pkg, fssc_in_if, fssc_out_if, fssc_prep, fssc_advance, fssc_report.
module frame_subframe_slot_counter (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [2:0] cfg_wdata,
	fssc_in_if.sink    items,
	fssc_out_if.source results
);
	import fssc_pkg::*;

	logic [2:0] num_q;
	logic [2:0] num;
	logic       v_s1, v_s2, v_s3, v_s4;
	logic       rdy1, rdy2, rdy3, rdy4;
	item_t      item_in;
	item_t      item_s1;
	dec_t       dec_c;
	dec_t       dec_s2;
	ctr_t       ctr_nxt;
	post_t      post_s3;
	res_t       res_c;
	res_t       res_s4;

	// Values six and seven behave as five.
	assign num = (num_q > MAX_NUMEROLOGY) ? MAX_NUMEROLOGY : num_q;

	assign rdy4 = !v_s4 || results.ready;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign items.ready = rdy1;

	assign item_in.opcode         = items.opcode;
	assign item_in.slot_count     = items.slot_count;
	assign item_in.load_encoding  = items.load_encoding;
	assign item_in.probe_encoding = items.probe_encoding;
	assign item_in.sym_start      = items.sym_start;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_q <= '0;
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s4  <= 1'b0;
		end else begin
			if (cfg_we) begin
				num_q <= cfg_wdata;
			end
			if (rdy1) begin
				v_s1 <= items.valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (items.valid && rdy1) begin
			item_s1 <= item_in;
		end
		if (v_s1 && rdy2) begin
			dec_s2 <= dec_c;
		end
		if (v_s2 && rdy3) begin
			post_s3.ctr       <= ctr_nxt;
			post_s3.refused   <= dec_s2.refused;
			post_s3.mismatch  <= dec_s2.mismatch;
			post_s3.pr_frame  <= dec_s2.pr_frame;
			post_s3.pr_sub    <= dec_s2.pr_sub;
			post_s3.pr_slot   <= dec_s2.pr_slot;
			post_s3.sym_start <= dec_s2.sym_start;
		end
		if (v_s3 && rdy4) begin
			res_s4 <= res_c;
		end
	end

	fssc_prep u_prep (
		.item (item_s1),
		.num  (num),
		.dec  (dec_c)
	);

	// The counter steps only when its transfer into the third stage takes place.
	fssc_advance u_advance (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (v_s2 && rdy3),
		.num    (num),
		.dec    (dec_s2),
		.nxt    (ctr_nxt)
	);

	fssc_report u_report (
		.post (post_s3),
		.num  (num),
		.res  (res_c)
	);

	assign results.valid               = v_s4;
	assign results.frame_number        = res_s4.frame_number;
	assign results.subframe_number     = res_s4.subframe_number;
	assign results.slot_number         = res_s4.slot_number;
	assign results.absolute_slot       = res_s4.absolute_slot;
	assign results.time_encoding       = res_s4.time_encoding;
	assign results.is_before_probe     = res_s4.is_before_probe;
	assign results.equals_probe        = res_s4.equals_probe;
	assign results.numerology_mismatch = res_s4.numerology_mismatch;
	assign results.load_refused        = res_s4.load_refused;
endmodule

>>> sv/fssc_prep.sv
// First stage: splits the slot count and decodes the load and probe encodings.
// Uses fssc_pkg; independent of the counter state.
module fssc_prep (
	input  fssc_pkg::item_t item,
	input  logic [2:0]      num,
	output fssc_pkg::dec_t  dec
);
	import fssc_pkg::*;

	logic [31:0] cnt_hi;
	logic [63:0] prod;
	logic [4:0]  mask;
	logic [8:0]  spsf;
	logic [7:0]  ld_sub_b;
	logic [7:0]  ld_slot_b;

	assign spsf   = 9'd1 << num;
	assign mask   = 5'(spsf - 9'd1);
	assign cnt_hi = item.slot_count >> num;
	// Quotient by ten of a 32-bit value is exact with this reciprocal and shift.
	assign prod   = 64'(cnt_hi) * 64'(RECIP10);

	assign ld_sub_b  = item.load_encoding[31:24];
	assign ld_slot_b = item.load_encoding[23:16];

	always_comb begin
		dec.opcode     = item.opcode;
		dec.cnt_lo     = item.slot_count[4:0] & mask;
		dec.cnt_hi_lsb = cnt_hi[3:0];
		dec.cnt_quot   = prod[63:35];
		dec.ld_frame   = item.load_encoding[32 +: FRAME_BITS];
		dec.ld_sub     = ld_sub_b[3:0];
		dec.ld_slot    = ld_slot_b[4:0];
		dec.refused    = (item.opcode == OP_LOAD) &&
			((ld_sub_b >= 8'(SUBFRAMES)) || ({1'b0, ld_slot_b} >= spsf));
		dec.mismatch   = (item.probe_encoding[15:8] != 8'(num)) ||
			((item.opcode == OP_LOAD) && (item.load_encoding[15:8] != 8'(num)));
		dec.pr_frame   = item.probe_encoding[32 +: FRAME_BITS];
		dec.pr_sub     = item.probe_encoding[31:24];
		dec.pr_slot    = item.probe_encoding[23:16];
		dec.sym_start  = item.sym_start;
	end
endmodule

>>> sv/fssc_advance.sv
// Second stage: holds the frame, subframe and slot registers and steps them.
// Uses fssc_pkg for the stage structures and div10_small.
module fssc_advance (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           en,
	input  logic [2:0]     num,
	input  fssc_pkg::dec_t dec,
	output fssc_pkg::ctr_t nxt
);
	import fssc_pkg::*;

	ctr_t       ctr_q;
	logic [5:0] lo_sum;
	logic [5:0] carry;
	logic [4:0] mask;
	logic [3:0] rem_hi;
	logic [3:0] ten_q;
	logic [6:0] sub_sum;
	qr_t        qr;

	assign mask   = 5'((6'd1 << num) - 6'd1);
	assign lo_sum = {1'b0, ctr_q.slot} + {1'b0, dec.cnt_lo};
	assign carry  = lo_sum >> num;
	// Low four bits of ten times the quotient are enough for the remainder.
	assign ten_q  = 4'({dec.cnt_quot[0], 3'b000} + {dec.cnt_quot[2:0], 1'b0});
	assign rem_hi = dec.cnt_hi_lsb - ten_q;
	assign sub_sum = 7'(ctr_q.sub) + 7'(rem_hi) + 7'(carry);
	assign qr     = div10_small(sub_sum);

	always_comb begin
		nxt = ctr_q;
		if (dec.opcode == OP_ADVANCE) begin
			nxt.slot  = lo_sum[4:0] & mask;
			nxt.sub   = qr.r;
			nxt.frame = FRAME_BITS'(SUM_W'(ctr_q.frame) + SUM_W'(dec.cnt_quot) +
				SUM_W'(qr.q));
		end else if (!dec.refused) begin
			nxt.frame = dec.ld_frame;
			nxt.sub   = dec.ld_sub;
			nxt.slot  = dec.ld_slot;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctr_q <= '0;
		end else if (en) begin
			ctr_q <= nxt;
		end
	end
endmodule

>>> sv/fssc_report.sv
// Third stage: forms the absolute slot, the encoding and the probe comparisons.
// Uses fssc_pkg for the stage and result structures.
module fssc_report (
	input  fssc_pkg::post_t post,
	input  logic [2:0]      num,
	output fssc_pkg::res_t  res
);
	import fssc_pkg::*;

	logic [ABS_W-1:0] f_w;
	logic [ABS_W-1:0] base;
	logic             f_eq;
	logic             sf_eq;
	logic             sl_eq;

	assign f_w   = ABS_W'(post.ctr.frame);
	assign base  = (f_w << 3) + (f_w << 1) + ABS_W'(post.ctr.sub);
	assign f_eq  = post.ctr.frame == post.pr_frame;
	assign sf_eq = {4'b0, post.ctr.sub} == post.pr_sub;
	assign sl_eq = {3'b0, post.ctr.slot} == post.pr_slot;

	always_comb begin
		res.frame_number     = 32'(post.ctr.frame);
		res.subframe_number  = post.ctr.sub;
		res.slot_number      = post.ctr.slot;
		res.absolute_slot    = (base << num) + ABS_W'(post.ctr.slot);
		res.time_encoding    = {32'(post.ctr.frame), 4'b0, post.ctr.sub, 3'b0,
			post.ctr.slot, 5'b0, num, post.sym_start};
		res.is_before_probe  = (post.ctr.frame < post.pr_frame) ||
			(f_eq && ({4'b0, post.ctr.sub} < post.pr_sub)) ||
			(f_eq && sf_eq && ({3'b0, post.ctr.slot} < post.pr_slot));
		res.equals_probe        = f_eq && sf_eq && sl_eq;
		res.numerology_mismatch = post.mismatch;
		res.load_refused        = post.refused;
	end
endmodule

>>> verif/frame_subframe_slot_counter_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for the frame, subframe and slot counter.
// Predicts every result from its own copy of the counter and numerology and checks it
// field by field. Depends on fssc_pkg, fssc_in_if, fssc_out_if and the counter RTL.
module frame_subframe_slot_counter_tb;
	import fssc_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int PHASE_ITEMS  = 115;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [2:0] cfg_wdata;

	fssc_in_if  item_ch();
	fssc_out_if report_ch();

	frame_subframe_slot_counter dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.items    (item_ch),
		.results  (report_ch)
	);

	ctr_t       model_ctr;
	logic [2:0] model_numer;
	res_t       due_reports[$];
	int         errors;
	int         cycle_count;
	int         max_send_gap;
	int         max_stall;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic logic [63:0] timestamp(input logic [31:0] f, input logic [7:0] sf,
			input logic [7:0] sl, input logic [7:0] nm, input logic [7:0] sym);
		return {f, sf, sl, nm, sym};
	endfunction

	function automatic logic [2:0] clamp_numer(input logic [2:0] numer);
		return (numer > MAX_NUMEROLOGY) ? MAX_NUMEROLOGY : numer;
	endfunction

	// Steps the counter by one item and returns the report it should produce.
	function automatic res_t count_and_report(input ctr_t cur, input logic [2:0] numer,
			input item_t it, output ctr_t nxt);
		logic [2:0]  n;
		logic [63:0] spsf;
		logic [63:0] total;
		logic [63:0] sft;
		logic [63:0] abs_full;
		logic [31:0] pframe;
		logic [7:0]  psub;
		logic [7:0]  pslot;
		logic [7:0]  lsub;
		logic [7:0]  lslot;
		logic        refused;
		logic        mism;
		res_t        r;
		n       = clamp_numer(numer);
		spsf    = 64'd1 << n;
		nxt     = cur;
		refused = 1'b0;
		mism    = 1'b0;
		if (it.opcode == OP_ADVANCE) begin
			total     = 64'(cur.slot) + 64'(it.slot_count);
			sft       = 64'(cur.sub) + (total >> n);
			nxt.slot  = 5'(total & (spsf - 64'd1));
			nxt.sub   = 4'(sft % 64'(SUBFRAMES));
			nxt.frame = cur.frame + 32'(sft / 64'(SUBFRAMES));
		end else begin
			lsub  = it.load_encoding[31:24];
			lslot = it.load_encoding[23:16];
			if (it.load_encoding[15:8] != {5'd0, n})
				mism = 1'b1;
			if (lsub >= {4'd0, SUBFRAMES} || 64'(lslot) >= spsf) begin
				refused = 1'b1;
			end else begin
				nxt.frame = it.load_encoding[63:32];
				nxt.sub   = 4'(lsub);
				nxt.slot  = 5'(lslot);
			end
		end
		pframe = it.probe_encoding[63:32];
		psub   = it.probe_encoding[31:24];
		pslot  = it.probe_encoding[23:16];
		if (it.probe_encoding[15:8] != {5'd0, n})
			mism = 1'b1;
		abs_full = ((64'(nxt.sub) + 64'(nxt.frame) * 64'(SUBFRAMES)) << n) + 64'(nxt.slot);
		r.frame_number        = nxt.frame;
		r.subframe_number     = nxt.sub;
		r.slot_number         = nxt.slot;
		r.absolute_slot       = abs_full[ABS_W-1:0];
		r.time_encoding       = timestamp(nxt.frame, {4'd0, nxt.sub}, {3'd0, nxt.slot},
			{5'd0, n}, it.sym_start);
		r.is_before_probe     = (nxt.frame < pframe) ||
			(nxt.frame == pframe && {4'd0, nxt.sub} < psub) ||
			(nxt.frame == pframe && {4'd0, nxt.sub} == psub && {3'd0, nxt.slot} < pslot);
		r.equals_probe        = nxt.frame == pframe && {4'd0, nxt.sub} == psub &&
			{3'd0, nxt.slot} == pslot;
		r.numerology_mismatch = mism;
		r.load_refused        = refused;
		return r;
	endfunction

	function automatic item_t make_item(input logic op, input logic [31:0] count,
			input logic [63:0] load, input logic [63:0] probe, input logic [7:0] sym);
		item_t it;
		it.opcode         = op;
		it.slot_count     = count;
		it.load_encoding  = load;
		it.probe_encoding = probe;
		it.sym_start      = sym;
		return it;
	endfunction

	// Mostly small advances and in-range loads, with probes placed on or next to the
	// counter value that the item will leave behind.
	function automatic item_t random_item();
		item_t      it;
		ctr_t       after;
		logic [2:0] n;
		logic [7:0] nm;
		logic [7:0] psub;
		logic [7:0] pslot;
		logic [31:0] pframe;
		logic [31:0] lframe;
		int         pick;
		n = clamp_numer(model_numer);
		it.opcode    = ($urandom_range(0, 9) < 7) ? OP_ADVANCE : OP_LOAD;
		it.sym_start = 8'($urandom_range(0, 255));
		pick = $urandom_range(0, 19);
		if (pick < 10)
			it.slot_count = $urandom_range(0, 40);
		else if (pick < 15)
			it.slot_count = $urandom_range(0, 2000);
		else if (pick < 18)
			it.slot_count = $urandom;
		else
			it.slot_count = 32'hFFFF_FFFF - $urandom_range(0, 40);

		lframe = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF - $urandom_range(0, 2) : $urandom;
		nm     = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : {5'd0, n};
		pick   = $urandom_range(0, 9);
		if (pick < 7)
			it.load_encoding = timestamp(lframe, 8'($urandom_range(0, 9)),
				8'($urandom_range(0, (1 << n) - 1)), nm, 8'($urandom_range(0, 255)));
		else if (pick == 7)
			it.load_encoding = timestamp(lframe, 8'($urandom_range(10, 255)),
				8'($urandom_range(0, (1 << n) - 1)), nm, 8'($urandom_range(0, 255)));
		else if (pick == 8)
			it.load_encoding = timestamp(lframe, 8'($urandom_range(0, 9)),
				8'($urandom_range(1 << n, 255)), nm, 8'($urandom_range(0, 255)));
		else
			it.load_encoding = {$urandom, $urandom};

		it.probe_encoding = 64'd0;
		void'(count_and_report(model_ctr, model_numer, it, after));
		pframe = after.frame;
		psub   = {4'd0, after.sub};
		pslot  = {3'd0, after.slot};
		nm     = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255)) : {5'd0, n};
		pick   = $urandom_range(0, 19);
		if (pick >= 7 && pick < 14) begin
			case ($urandom_range(0, 2))
				0: pframe = $urandom_range(0, 1) ? pframe + 32'd1 : pframe - 32'd1;
				1: psub   = $urandom_range(0, 1) ? psub + 8'd1 : psub - 8'd1;
				default: pslot = $urandom_range(0, 1) ? pslot + 8'd1 : pslot - 8'd1;
			endcase
		end
		if (pick < 14)
			it.probe_encoding = timestamp(pframe, psub, pslot, nm,
				8'($urandom_range(0, 255)));
		else
			it.probe_encoding = {$urandom, $urandom};
		return it;
	endfunction

	task automatic send_item(input item_t it);
		int   gap;
		ctr_t nxt;
		gap = $urandom_range(0, max_send_gap);
		if (gap != 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid          <= 1'b1;
		item_ch.opcode         <= it.opcode;
		item_ch.slot_count     <= it.slot_count;
		item_ch.load_encoding  <= it.load_encoding;
		item_ch.probe_encoding <= it.probe_encoding;
		item_ch.sym_start      <= it.sym_start;
		do @(posedge clk); while (!item_ch.ready);
		due_reports.push_back(count_and_report(model_ctr, model_numer, it, nxt));
		model_ctr = nxt;
	endtask

	// Leaves the pipeline empty so that the numerology register may be rewritten.
	task automatic drain();
		item_ch.valid <= 1'b0;
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_numerology(input logic [2:0] value);
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		model_numer = value;
	endtask

	task automatic test_reset_state();
		send_item(make_item(OP_ADVANCE, 32'd0, 64'd0, timestamp(0, 0, 0, 0, 0), 8'h00));
		send_item(make_item(OP_ADVANCE, 32'd0, 64'hFFFF_FFFF_FFFF_FFFF,
			timestamp(1, 0, 0, 3, 0), 8'hFF));
	endtask

	task automatic test_advance_carry();
		drain();
		set_numerology(3'd1);
		send_item(make_item(OP_ADVANCE, 32'd1, 64'd0, timestamp(0, 0, 1, 1, 0), 8'h5A));
		send_item(make_item(OP_ADVANCE, 32'd1, 64'd0, timestamp(0, 0, 9, 1, 0), 8'hA5));
		// Nineteen slots from subframe one crosses into the next frame.
		send_item(make_item(OP_ADVANCE, 32'd19, 64'd0, timestamp(1, 0, 1, 1, 0), 8'h01));
		send_item(make_item(OP_ADVANCE, 32'hFFFF_FFFF, 64'd0, 64'd0, 8'h80));
		send_item(make_item(OP_ADVANCE, 32'd0, 64'd0, 64'hFFFF_FFFF_FFFF_FFFF, 8'h7F));
	endtask

	task automatic test_load_checks();
		drain();
		set_numerology(3'd3);
		send_item(make_item(OP_LOAD, 32'hFFFF_FFFF, timestamp(32'hFFFF_FFFF, 9, 7, 3, 8'hFF),
			timestamp(32'hFFFF_FFFF, 9, 7, 3, 0), 8'h00));
		// The last slot of the last frame wraps round to zero.
		send_item(make_item(OP_ADVANCE, 32'd1, 64'd0,
			timestamp(32'hFFFF_FFFF, 9, 7, 3, 0), 8'hFF));
		send_item(make_item(OP_LOAD, 32'd0, timestamp(5, 10, 0, 3, 0),
			timestamp(0, 0, 0, 3, 0), 8'h11));
		send_item(make_item(OP_LOAD, 32'd0, timestamp(5, 8'hFF, 8'hFF, 3, 0),
			timestamp(0, 0, 1, 3, 0), 8'h22));
		send_item(make_item(OP_LOAD, 32'd0, timestamp(5, 2, 8, 3, 0),
			timestamp(5, 2, 8, 3, 0), 8'h33));
		// A differing numerology byte only raises the flag; the load still applies.
		send_item(make_item(OP_LOAD, 32'd0, timestamp(5, 2, 7, 8'hFF, 0),
			timestamp(5, 2, 7, 3, 0), 8'h44));
		send_item(make_item(OP_LOAD, 32'd0, 64'd0, timestamp(5, 2, 7, 3, 0), 8'h55));
	endtask

	task automatic test_numerology_limits();
		drain();
		set_numerology(3'd5);
		send_item(make_item(OP_LOAD, 32'd0, timestamp(5, 9, 31, 5, 0),
			timestamp(5, 9, 31, 5, 0), 8'h01));
		// Dropping to numerology zero leaves slot 31 stored; the next advance carries it.
		drain();
		set_numerology(3'd0);
		send_item(make_item(OP_ADVANCE, 32'd0, 64'd0, timestamp(5, 9, 31, 0, 0), 8'h02));
		send_item(make_item(OP_ADVANCE, 32'd1, 64'd0, timestamp(9, 1, 0, 0, 0), 8'h03));
		drain();
		set_numerology(3'd6);
		send_item(make_item(OP_ADVANCE, 32'd0, 64'd0, timestamp(9, 1, 0, 6, 0), 8'h04));
		send_item(make_item(OP_ADVANCE, 32'd33, 64'd0, timestamp(9, 2, 1, 5, 0), 8'h05));
		drain();
		set_numerology(3'd7);
		send_item(make_item(OP_LOAD, 32'd0, timestamp(32'hFFFF_FFFE, 0, 31, 7, 0),
			timestamp(32'hFFFF_FFFE, 0, 31, 5, 0), 8'h06));
		send_item(make_item(OP_ADVANCE, 32'd1, 64'd0, timestamp(32'hFFFF_FFFE, 1, 0, 5, 0),
			8'h07));
	endtask

	task automatic test_random_traffic();
		logic [2:0] settings[10];
		settings = '{3'd3, 3'd0, 3'd5, 3'd6, 3'd1, 3'd7, 3'd2, 3'd4, 3'd0, 3'd5};
		for (int p = 0; p < 10; p++) begin
			drain();
			set_numerology(settings[p]);
			// Rotate through both sides idling, neither idling, and one side only.
			max_send_gap = (p % 4 == 0 || p % 4 == 3) ? 7 : 0;
			max_stall    = (p % 4 == 0 || p % 4 == 2) ? 7 : 0;
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_item(random_item());
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h, got %0h", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		res_t want;
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("%0t: no progress within the cycle limit", $time);
			$display("** frame_subframe_slot_counter: FAILED **");
			$finish;
		end else if (arst_n && report_ch.valid && report_ch.ready) begin
			if (due_reports.size() == 0) begin
				$display("%0t: result transfer with nothing expected, frame %0h", $time,
					report_ch.frame_number);
				errors++;
			end else begin
				want = due_reports.pop_front();
				check_field("frame_number", 64'(want.frame_number),
					64'(report_ch.frame_number));
				check_field("subframe_number", 64'(want.subframe_number),
					64'(report_ch.subframe_number));
				check_field("slot_number", 64'(want.slot_number),
					64'(report_ch.slot_number));
				check_field("absolute_slot", 64'(want.absolute_slot),
					64'(report_ch.absolute_slot));
				check_field("time_encoding", want.time_encoding, report_ch.time_encoding);
				check_field("is_before_probe", 64'(want.is_before_probe),
					64'(report_ch.is_before_probe));
				check_field("equals_probe", 64'(want.equals_probe),
					64'(report_ch.equals_probe));
				check_field("numerology_mismatch", 64'(want.numerology_mismatch),
					64'(report_ch.numerology_mismatch));
				check_field("load_refused", 64'(want.load_refused),
					64'(report_ch.load_refused));
			end
		end
	end

	// Result side: a fresh stall is drawn for every transfer.
	initial begin
		int stall;
		report_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = $urandom_range(0, max_stall);
			if (stall != 0) begin
				report_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			report_ch.ready <= 1'b1;
			do @(posedge clk); while (!(report_ch.valid && report_ch.ready));
		end
	end

	initial begin
		errors       = 0;
		cycle_count  = 0;
		max_send_gap = 7;
		max_stall    = 7;
		model_ctr    = '0;
		model_numer  = 3'd0;
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = 3'd0;
		item_ch.valid          = 1'b0;
		item_ch.opcode         = OP_ADVANCE;
		item_ch.slot_count     = '0;
		item_ch.load_encoding  = '0;
		item_ch.probe_encoding = '0;
		item_ch.sym_start      = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_state();
		test_advance_carry();
		test_load_checks();
		test_numerology_limits();
		test_random_traffic();

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("** frame_subframe_slot_counter: PASSED **");
		else
			$display("** frame_subframe_slot_counter: FAILED **");
		$finish;
	end

endmodule

>>> files.f
sv/fssc_pkg.sv
sv/fssc_in_if.sv
sv/fssc_out_if.sv
sv/fssc_prep.sv
sv/fssc_advance.sv
sv/fssc_report.sv
sv/frame_subframe_slot_counter.sv
verif/frame_subframe_slot_counter_tb.sv
